// ===== src/cdfb_pkg.sv =====
// Shared types and constants for the calibrated DAC frame builder.
package cdfb_pkg;

    localparam int VOLT_FRACTION_BITS_DEF = 16;

    localparam int NUM_CH    = 4;
    localparam int CH_W      = 2;
    localparam int CODE_W    = 16;
    localparam int VOLTS_W   = 21;
    localparam int CFG_IDX_W = 4;

    localparam logic [7:0]        CMD_BASE       = 8'h10;
    localparam logic [CODE_W-1:0] CAL_RESET_LOW  = 16'd0;
    localparam logic [CODE_W-1:0] CAL_RESET_HIGH = 16'd26214;

    // Register index map
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOW_BASE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HIGH_BASE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_END       = 4'd8;

    typedef enum logic {
        MODE_RAW   = 1'b0,
        MODE_PITCH = 1'b1
    } t_mode;

    typedef logic [NUM_CH-1:0][CODE_W-1:0] t_code_vec;

    typedef struct packed {
        t_code_vec lo;
        t_code_vec hi;
    } t_cal_set;

endpackage

// ===== src/cdfb_cal_regs.sv =====
// Calibration register file: low and high codes for the four channels.
module cdfb_cal_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [cdfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cdfb_pkg::CODE_W-1:0]    i_cfg_data,
    output cdfb_pkg::t_cal_set             o_cal
);

    cdfb_pkg::t_code_vec r_lo;
    cdfb_pkg::t_code_vec r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cdfb_pkg::NUM_CH; i++) begin
                r_lo[i] <= cdfb_pkg::CAL_RESET_LOW;
                r_hi[i] <= cdfb_pkg::CAL_RESET_HIGH;
            end
        end else if (i_cfg_valid) begin
            // drop writes beyond the last register
            if (i_cfg_index < cdfb_pkg::CFG_IDX_HIGH_BASE) begin
                r_lo[i_cfg_index[cdfb_pkg::CH_W-1:0]] <= i_cfg_data;
            end else if (i_cfg_index < cdfb_pkg::CFG_IDX_END) begin
                r_hi[i_cfg_index[cdfb_pkg::CH_W-1:0]] <= i_cfg_data;
            end
        end
    end

    assign o_cal.lo = r_lo;
    assign o_cal.hi = r_hi;

endmodule

// ===== src/calibrated_dac_frame_builder.sv =====
// Calibrated DAC frame builder: raw code pass-through or pitch interpolation.
// Pipeline: clamp stage, then multiply / shift / add stage into the output register.
// Throughput: one item per cycle while the output does not stall; the single
// 17 x (F+5) bit multiplier sets the critical path. An empty stage 1 still
// takes a request while the output stalls.
// Reset: pipeline empty, cal_low_* = 0, cal_high_* = 26214. No clearing pass.
module calibrated_dac_frame_builder #(
    parameter int VOLT_FRACTION_BITS = cdfb_pkg::VOLT_FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input request
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // channel[1:0], raw_code[17:2], volts[38:18], zero[39]
    input  logic        i_s_tuser,  // mode[0]
    // result
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // code[15:0], frame[39:16]
    // configuration write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cdfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cdfb_pkg::CODE_W-1:0]    i_cfg_data
);

    localparam int F    = VOLT_FRACTION_BITS;
    localparam int XW   = F + 4;  // holds 8 * 2^F
    localparam int SW   = (((F + 5) > 22) ? (F + 5) : 22) + 1;
    localparam int DW   = cdfb_pkg::CODE_W + 1;
    localparam int PW   = DW + XW + 1;
    localparam int SH   = F + 3;

    localparam logic signed [SW-1:0] VOLT_OFS  = SW'(longint'(2) << F);
    localparam logic signed [SW-1:0] SPAN_S    = SW'(longint'(8) << F);
    localparam logic        [XW-1:0] SPAN_X    = XW'(longint'(8) << F);

    cdfb_pkg::t_cal_set w_cal;

    cdfb_cal_regs u_cal_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cal       (w_cal)
    );

    assign o_cfg_ready = 1'b1;

    // ---------------- stage 1: field split, clamp, calibration select
    logic [cdfb_pkg::CH_W-1:0]    w_ch;
    logic [cdfb_pkg::CODE_W-1:0]  w_raw;
    logic [cdfb_pkg::VOLTS_W-1:0] w_volts;
    logic signed [SW-1:0]         w_v_ext;
    logic signed [SW-1:0]         w_t;
    logic [cdfb_pkg::CODE_W-1:0]  w_lo;
    logic [cdfb_pkg::CODE_W-1:0]  w_hi;
    logic [XW-1:0]                n_x;
    logic [cdfb_pkg::CODE_W-1:0]  n_hi_eff;
    logic signed [DW-1:0]         n_diff;

    assign w_ch    = i_s_tdata[1:0];
    assign w_raw   = i_s_tdata[17:2];
    assign w_volts = i_s_tdata[38:18];
    assign w_v_ext = SW'($signed(w_volts));
    assign w_t     = w_v_ext + VOLT_OFS;
    assign w_lo    = w_cal.lo[w_ch];
    assign w_hi    = w_cal.hi[w_ch];

    always_comb begin
        if (w_t <= 0) begin
            n_x = '0;
        end else if (w_t >= SPAN_S) begin
            n_x = SPAN_X;
        end else begin
            n_x = w_t[XW-1:0];
        end
        // equal codes: treat high as low + 1, wrapping
        n_hi_eff = (w_hi == w_lo) ? (w_lo + 16'd1) : w_hi;
        n_diff   = $signed({1'b0, n_hi_eff}) - $signed({1'b0, w_lo});
    end

    logic                         r_s1_valid;
    cdfb_pkg::t_mode              r_s1_mode;
    logic [cdfb_pkg::CH_W-1:0]    r_s1_ch;
    logic [cdfb_pkg::CODE_W-1:0]  r_s1_raw;
    logic [XW-1:0]                r_s1_x;
    logic [cdfb_pkg::CODE_W-1:0]  r_s1_lo;
    logic signed [DW-1:0]         r_s1_diff;

    logic w_adv;
    logic r_m_valid;

    assign w_adv      = !r_m_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_s1_mode <= cdfb_pkg::t_mode'(i_s_tuser);
            r_s1_ch   <= w_ch;
            r_s1_raw  <= w_raw;
            r_s1_x    <= n_x;
            r_s1_lo   <= w_lo;
            r_s1_diff <= n_diff;
        end
    end

    // ---------------- stage 2: interpolate, floor, select
    logic signed [PW-1:0]        w_prod;
    logic signed [PW-1:0]        w_prod_sh;
    logic signed [DW-1:0]        w_sum;
    logic [cdfb_pkg::CODE_W-1:0] n_code;

    assign w_prod    = PW'(r_s1_diff) * PW'($signed({1'b0, r_s1_x}));
    assign w_prod_sh = w_prod >>> SH;  // floor division by the span
    assign w_sum     = $signed({1'b0, r_s1_lo}) + w_prod_sh[DW-1:0];

    always_comb begin
        case (r_s1_mode)
            cdfb_pkg::MODE_RAW:   n_code = r_s1_raw;
            cdfb_pkg::MODE_PITCH: n_code = w_sum[cdfb_pkg::CODE_W-1:0];
            default:              n_code = r_s1_raw;
        endcase
    end

    logic [cdfb_pkg::CODE_W-1:0] r_m_code;
    logic [cdfb_pkg::CH_W-1:0]   r_m_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_m_code <= n_code;
            r_m_ch   <= r_s1_ch;
        end
    end

    logic [7:0] w_cmd;
    assign w_cmd      = cdfb_pkg::CMD_BASE | {5'd0, r_m_ch, 1'b0};
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {w_cmd, r_m_code, r_m_code};

    // ---------------- assertions
    a_no_accept_into_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> (!r_s1_valid || w_adv))
        else $error("input request taken while stage 1 held");

    a_raw_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_adv && (r_s1_mode == cdfb_pkg::MODE_RAW))
        |=> (r_m_valid && (o_m_tdata[15:0] == $past(r_s1_raw))))
        else $error("raw code not passed through");

    a_low_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_adv && (r_s1_mode == cdfb_pkg::MODE_PITCH) && (r_s1_x == '0))
        |=> (o_m_tdata[15:0] == $past(r_s1_lo)))
        else $error("voltage at low limit did not give low code");

    a_stage_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_adv) |=> r_m_valid)
        else $error("stage 1 item lost");

endmodule
